// ===== src/itp_pkg.sv =====
// Shared types, constants and code tables for the infix-to-postfix converter.
// No dependencies; used by itp_stack, infix_to_postfix_converter_core and tb.
`default_nettype none

package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef logic [2:0] code_t;
  typedef logic [1:0] prec_t;

  localparam code_t CODE_OPEN = 3'd0;
  localparam code_t CODE_ADD  = 3'd1;
  localparam code_t CODE_SUB  = 3'd2;
  localparam code_t CODE_MUL  = 3'd3;
  localparam code_t CODE_DIV  = 3'd4;
  localparam code_t CODE_MOD  = 3'd5;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // stack control, top level -> stack
  typedef struct packed {
    logic  push;
    logic  pop;
    code_t code;
  } stk_ctrl_t;

  // stack status, stack -> top level
  typedef struct packed {
    code_t            top;
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } stk_stat_t;

  function automatic logic [7:0] code_char(input code_t c);
    logic [7:0] r;
    case (c)
      CODE_ADD: r = CH_ADD;
      CODE_SUB: r = CH_SUB;
      CODE_MUL: r = CH_MUL;
      CODE_DIV: r = CH_DIV;
      CODE_MOD: r = CH_MOD;
      default:  r = CH_OPEN;
    endcase
    return r;
  endfunction

  function automatic prec_t code_prec(input code_t c);
    prec_t r;
    case (c)
      CODE_ADD, CODE_SUB:           r = 2'd1;
      CODE_MUL, CODE_DIV, CODE_MOD: r = 2'd2;
      default:                      r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/itp_stack.sv =====
// Bounded operator stack: register array with a fill count.
// Depends on itp_pkg.
`default_nettype none

module itp_stack (
  input  wire              clk,
  input  wire              rst_n,
  input  itp_pkg::stk_ctrl_t ctrl,
  output itp_pkg::stk_stat_t stat
);

  itp_pkg::code_t                mem [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::CNT_W-1:0]     count_r;
  logic [itp_pkg::CNT_W-1:0]     count_nxt;
  logic [itp_pkg::CNT_W-1:0]     top_pos;
  logic                          full;
  logic                          empty;

  assign full    = (count_r == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
  assign empty   = (count_r == '0);
  assign top_pos = count_r - itp_pkg::CNT_W'(1);

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push && !full) begin
      count_nxt = count_r + itp_pkg::CNT_W'(1);
    end else if (ctrl.pop && !empty) begin
      count_nxt = top_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // payload store, no reset: slots at or above the count are never used
  always_ff @(posedge clk) begin
    if (ctrl.push && !full) begin
      mem[count_r[itp_pkg::IDX_W-1:0]] <= ctrl.code;
    end
  end

  assign stat.top   = mem[top_pos[itp_pkg::IDX_W-1:0]];
  assign stat.count = count_r;
  assign stat.empty = empty;
  assign stat.full  = full;

endmodule

`default_nettype wire

// ===== src/infix_to_postfix_converter_core.sv =====
// Top level of the shunting-yard infix-to-postfix converter: sequencer,
// precedence compare, hold/output registers. Depends on itp_pkg, itp_stack.
//
// Usage:
// - Input channel (in_valid/in_stall): one ASCII character per beat, with
//   in_last marking the final character of an expression. Letters are
//   operands, ( ) + - * / % are handled by the operator stack, all other
//   bytes are ignored.
// - Output channel (out_valid/out_stall): one postfix symbol per beat.
//   out_has_symbol low marks an empty end marker; out_last flags the final
//   beat of an expression; out_overflow is the sticky stack-full flag.
// - Throughput: a character passes S_IDLE, S_DECODE, S_FLUSH and S_END (and
//   S_OPPOP or S_CLOSE for an operator or ')'); the single precedence compare
//   and one stack port allow one pop a cycle while the output is not stalled.
// - Latency: each result is held one step in a hold register so that the
//   final beat can be flagged; it leaves when the next result is made or
//   when the character finishes.
// - Reset (rst_n low, synchronous) empties the stack, clears the overflow
//   flag and drops any held or pending beat.
// - A stalled output holds its beat; the sequencer waits while the output
//   beat is stalled, and in_stall stays high until the character is done.
`default_nettype none

module infix_to_postfix_converter_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_char,
  input  wire        in_last,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_char,
  output logic       out_has_symbol,
  output logic       out_last,
  output logic       out_overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLOSE,
    S_OPPOP,
    S_FLUSH,
    S_END
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       overflow_r, overflow_nxt;
  logic       hold_valid_r, hold_valid_nxt;
  logic [7:0] hold_char_r, hold_char_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_has_r, out_has_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_ovf_r, out_ovf_nxt;

  itp_pkg::stk_ctrl_t ctrl;
  itp_pkg::stk_stat_t stat;

  logic           is_letter;
  logic           is_op;
  itp_pkg::code_t op_code;
  logic           pop_wins;
  logic           out_free;
  logic           can_emit;
  logic           emit_req;
  logic [7:0]     emit_char;
  logic           rel_req;

  itp_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // character classes
  assign is_letter = ((char_r >= 8'h61) && (char_r <= 8'h7A)) ||
                     ((char_r >= 8'h41) && (char_r <= 8'h5A));

  always_comb begin
    is_op   = 1'b1;
    op_code = itp_pkg::CODE_OPEN;
    unique case (char_r)
      itp_pkg::CH_ADD: op_code = itp_pkg::CODE_ADD;
      itp_pkg::CH_SUB: op_code = itp_pkg::CODE_SUB;
      itp_pkg::CH_MUL: op_code = itp_pkg::CODE_MUL;
      itp_pkg::CH_DIV: op_code = itp_pkg::CODE_DIV;
      itp_pkg::CH_MOD: op_code = itp_pkg::CODE_MOD;
      default:         is_op   = 1'b0;
    endcase
  end

  // precedence compare: does the stacked operator bind at least as tightly?
  assign pop_wins = !stat.empty && (stat.top != itp_pkg::CODE_OPEN) &&
                    (itp_pkg::code_prec(stat.top) >= itp_pkg::code_prec(op_code));

  assign out_free = !out_valid_r || !out_stall;
  // a new result pushes the held one out, so the output slot must be free
  assign can_emit = !hold_valid_r || out_free;

  always_comb begin
    state_nxt      = state_r;
    char_nxt       = char_r;
    last_nxt       = last_r;
    overflow_nxt   = overflow_r;
    hold_valid_nxt = hold_valid_r;
    hold_char_nxt  = hold_char_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_char_nxt   = out_char_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    ctrl           = '0;
    emit_req       = 1'b0;
    emit_char      = itp_pkg::CH_NUL;
    rel_req        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          char_nxt  = in_char;
          last_nxt  = in_last;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (is_letter) begin
          if (can_emit) begin
            emit_req  = 1'b1;
            emit_char = char_r;
            state_nxt = S_FLUSH;
          end
        end else if (char_r == itp_pkg::CH_OPEN) begin
          ctrl.push = 1'b1;
          ctrl.code = itp_pkg::CODE_OPEN;
          state_nxt = S_FLUSH;
        end else if (char_r == itp_pkg::CH_CLOSE) begin
          state_nxt = S_CLOSE;
        end else if (is_op) begin
          state_nxt = S_OPPOP;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_CLOSE: begin
        if (stat.empty) begin
          state_nxt = S_FLUSH;
        end else if (stat.top == itp_pkg::CODE_OPEN) begin
          ctrl.pop  = 1'b1;
          state_nxt = S_FLUSH;
        end else if (can_emit) begin
          ctrl.pop  = 1'b1;
          emit_req  = 1'b1;
          emit_char = itp_pkg::code_char(stat.top);
        end
      end
      S_OPPOP: begin
        if (pop_wins) begin
          if (can_emit) begin
            ctrl.pop  = 1'b1;
            emit_req  = 1'b1;
            emit_char = itp_pkg::code_char(stat.top);
          end
        end else begin
          ctrl.push = 1'b1;
          ctrl.code = op_code;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!last_r || stat.empty) begin
          state_nxt = S_END;
        end else if (can_emit) begin
          ctrl.pop  = 1'b1;
          emit_req  = 1'b1;
          emit_char = itp_pkg::code_char(stat.top);
        end
      end
      S_END: begin
        if (last_r || hold_valid_r) begin
          if (out_free) begin
            rel_req        = 1'b1;
            hold_valid_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a push onto a full stack is dropped by the stack; remember it
    if (ctrl.push && stat.full) begin
      overflow_nxt = 1'b1;
    end

    if (emit_req) begin
      if (hold_valid_r) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = hold_char_r;
        out_has_nxt   = 1'b1;
        out_last_nxt  = 1'b0;
        out_ovf_nxt   = overflow_r;
      end
      hold_valid_nxt = 1'b1;
      hold_char_nxt  = emit_char;
    end

    // end of character: held result goes out, or an empty marker if none
    if (rel_req) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = hold_valid_r ? hold_char_r : itp_pkg::CH_NUL;
      out_has_nxt   = hold_valid_r;
      out_last_nxt  = last_r;
      out_ovf_nxt   = overflow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      overflow_r   <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      overflow_r   <= overflow_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    last_r      <= last_nxt;
    hold_char_r <= hold_char_nxt;
    out_char_r  <= out_char_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_has_symbol = out_has_r;
  assign out_last       = out_last_r;
  assign out_overflow   = out_ovf_r;

`ifndef SYNTHESIS
  // the sequencer never pushes and pops in one cycle
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.push && ctrl.pop))
    else $error("stack push and pop in the same cycle");

  // overflow is sticky until reset
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |=> overflow_r)
    else $error("overflow flag cleared without reset");

  // a held result is never lost while the output register is blocked
  a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && out_valid_r && out_stall) |=> hold_valid_r)
    else $error("held result dropped while output stalled");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for infix_to_postfix_converter_core: a queue-fed
// driver, a monitor with a shunting-yard predictor, random idling and stalls.
// Depends on itp_pkg and the converter RTL only.
`timescale 1ns / 100ps

module tb;

  // cycles with no beat on either channel before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  // settling time after the last expected beat; covers a full stack flush
  localparam int DRAIN_CYCLES = 64;
  // per-phase random quota of meaningful characters
  localparam int PHASE_CHARS = 50;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [7:0] sym_char;
    logic       has_sym;
    logic       last;
    logic       ovf;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_has_symbol;
  logic       out_last;
  logic       out_overflow;

  // idling controls, changed per phase by the stimulus block
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  char_item_t pending_chars[$];
  char_item_t next_item;
  logic [7:0] expr_chars[$];
  int unsigned char_count;

  // predictor state: our own copy of the operator stack
  itp_pkg::code_t op_stack[itp_pkg::STACK_DEPTH];
  int unsigned    stack_fill = 0;
  logic           ovf_seen = 1'b0;
  beat_t          postfix_beats[$];
  beat_t          want;

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  infix_to_postfix_converter_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_has_symbol (out_has_symbol),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [1:0] op_rank(input itp_pkg::code_t c);
    logic [1:0] r;
    case (c)
      itp_pkg::CODE_ADD, itp_pkg::CODE_SUB: r = 2'd1;
      itp_pkg::CODE_MUL, itp_pkg::CODE_DIV,
      itp_pkg::CODE_MOD:                    r = 2'd2;
      default:                              r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_symbol(input itp_pkg::code_t c);
    logic [7:0] r;
    case (c)
      itp_pkg::CODE_ADD: r = itp_pkg::CH_ADD;
      itp_pkg::CODE_SUB: r = itp_pkg::CH_SUB;
      itp_pkg::CODE_MUL: r = itp_pkg::CH_MUL;
      itp_pkg::CODE_DIV: r = itp_pkg::CH_DIV;
      itp_pkg::CODE_MOD: r = itp_pkg::CH_MOD;
      default:           r = itp_pkg::CH_OPEN;
    endcase
    return r;
  endfunction

  function automatic beat_t sym_beat(input logic [7:0] c);
    beat_t b;
    b.sym_char = c;
    b.has_sym  = 1'b1;
    b.last     = 1'b0;
    b.ovf      = 1'b0;
    return b;
  endfunction

  // full stack: the push is lost and the sticky flag goes up
  function automatic void push_code(input itp_pkg::code_t c);
    if (stack_fill >= itp_pkg::STACK_DEPTH) begin
      ovf_seen = 1'b1;
    end else begin
      op_stack[stack_fill] = c;
      stack_fill++;
    end
  endfunction

  // Works out the postfix beats caused by one accepted character.
  function automatic void convert_char(input logic [7:0] c, input logic last);
    beat_t          step_beats[$];
    beat_t          empty_mark;
    itp_pkg::code_t code;
    itp_pkg::code_t top;
    logic           is_op;
    logic           matched;
    is_op = 1'b1;
    case (c)
      itp_pkg::CH_ADD: code = itp_pkg::CODE_ADD;
      itp_pkg::CH_SUB: code = itp_pkg::CODE_SUB;
      itp_pkg::CH_MUL: code = itp_pkg::CODE_MUL;
      itp_pkg::CH_DIV: code = itp_pkg::CODE_DIV;
      itp_pkg::CH_MOD: code = itp_pkg::CODE_MOD;
      default: begin
        code  = itp_pkg::CODE_OPEN;
        is_op = 1'b0;
      end
    endcase

    if (is_letter(c)) begin
      step_beats.push_back(sym_beat(c));
    end else if (c == itp_pkg::CH_OPEN) begin
      push_code(itp_pkg::CODE_OPEN);
    end else if (c == itp_pkg::CH_CLOSE) begin
      // pop down to the nearest open paren, or empty the stack if none
      matched = 1'b0;
      while (!matched && stack_fill != 0) begin
        stack_fill--;
        top = op_stack[stack_fill];
        if (top == itp_pkg::CODE_OPEN) matched = 1'b1;
        else step_beats.push_back(sym_beat(op_symbol(top)));
      end
    end else if (is_op) begin
      while (stack_fill != 0 && op_stack[stack_fill-1] != itp_pkg::CODE_OPEN &&
             op_rank(op_stack[stack_fill-1]) >= op_rank(code)) begin
        stack_fill--;
        step_beats.push_back(sym_beat(op_symbol(op_stack[stack_fill])));
      end
      push_code(code);
    end

    if (last) begin
      // flush everything, unmatched open parens included
      while (stack_fill != 0) begin
        stack_fill--;
        step_beats.push_back(sym_beat(op_symbol(op_stack[stack_fill])));
      end
      if (step_beats.size() == 0) begin
        empty_mark         = sym_beat(itp_pkg::CH_NUL);
        empty_mark.has_sym = 1'b0;
        step_beats.push_back(empty_mark);
      end
      step_beats[step_beats.size()-1].last = 1'b1;
    end

    foreach (step_beats[i]) begin
      step_beats[i].ovf = ovf_seen;
      postfix_beats.push_back(step_beats[i]);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued characters, holds them while stalled
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_chars.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        next_item = pending_chars.pop_front();
        in_valid <= 1'b1;
        in_char  <= next_item.ch;
        in_last  <= next_item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: check the output beat first, then predict from the input
  // beat taken at the same edge; both sampled before any update lands.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (postfix_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char %h", out_char));
        end else begin
          want = postfix_beats.pop_front();
          if (out_char !== want.sym_char)
            report_mismatch($sformatf("out_char %h, want %h", out_char, want.sym_char));
          if (out_has_symbol !== want.has_sym)
            report_mismatch($sformatf("out_has_symbol %b, want %b",
                                      out_has_symbol, want.has_sym));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %b, want %b", out_last, want.last));
          if (out_overflow !== want.ovf)
            report_mismatch($sformatf("out_overflow %b, want %b", out_overflow, want.ovf));
        end
      end
      if (in_valid && !in_stall) convert_char(in_char, in_last);

      // watchdog on a silent interface
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------

  // counts toward the phase quota unless the block would just drop it
  task automatic queue_char(input logic [7:0] c, input logic last);
    char_item_t it;
    it.ch   = c;
    it.last = last;
    pending_chars.push_back(it);
    if (last || is_letter(c) ||
        (c inside {itp_pkg::CH_OPEN, itp_pkg::CH_CLOSE, itp_pkg::CH_ADD,
                   itp_pkg::CH_SUB, itp_pkg::CH_MUL, itp_pkg::CH_DIV,
                   itp_pkg::CH_MOD}))
      char_count++;
  endtask

  task automatic queue_string(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      queue_char(s[i], last_at_end && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) != 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_op();
    logic [7:0] r;
    case ($urandom_range(0, 4))
      0:       r = itp_pkg::CH_ADD;
      1:       r = itp_pkg::CH_SUB;
      2:       r = itp_pkg::CH_MUL;
      3:       r = itp_pkg::CH_DIV;
      default: r = itp_pkg::CH_MOD;
    endcase
    return r;
  endfunction

  // Nesting is kept to three levels, so a well-formed expression never
  // fills the stack; overflow is provoked on purpose at the very end.
  task automatic add_term(input int depth);
    if (depth > 0 && $urandom_range(0, 3) == 0) begin
      expr_chars.push_back(itp_pkg::CH_OPEN);
      add_expr(depth - 1);
      expr_chars.push_back(itp_pkg::CH_CLOSE);
    end else begin
      expr_chars.push_back(rand_letter());
    end
    if ($urandom_range(0, 7) == 0) expr_chars.push_back(" ");
  endtask

  task automatic add_expr(input int depth);
    int n_ops;
    n_ops = $urandom_range(0, 3);
    add_term(depth);
    repeat (n_ops) begin
      expr_chars.push_back(rand_op());
      add_term(depth);
    end
  endtask

  task automatic queue_expression();
    expr_chars.delete();
    add_expr(3);
    // now and then the closing flag rides on an ignored byte
    if ($urandom_range(0, 5) == 0) expr_chars.push_back(" ");
    foreach (expr_chars[i]) queue_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  // short broken sequences: stray parens, dangling operators, any byte
  task automatic queue_noise();
    int len;
    logic [7:0] c;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0:       c = rand_letter();
        1:       c = rand_op();
        2:       c = itp_pkg::CH_OPEN;
        3:       c = itp_pkg::CH_CLOSE;
        4:       c = " ";
        default: c = 8'($urandom_range(0, 255));
      endcase
      queue_char(c, i == len - 1);
    end
  endtask

  task automatic wait_sent();
    while (pending_chars.size() != 0 || in_valid) @(posedge clk);
  endtask

  int unsigned idle_tab[4]  = '{0, 61, 0, 24};
  int unsigned stall_tab[4] = '{0, 0, 61, 24};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: precedence, both letter-case extremes, every operator
    queue_string("A+z*Z", 1'b1);
    queue_string("(a-b)/c%d", 1'b1);
    // close paren with no open paren on the stack, then an empty end
    queue_string("a*b)", 1'b0);
    queue_char(8'h00, 1'b1);
    queue_char(8'hFF, 1'b1);
    // unmatched open paren flushed at the end of the expression
    queue_string("(a+", 1'b1);
    queue_char(itp_pkg::CH_OPEN, 1'b1);
    wait_sent();

    // random phases with varying idle and stall pressure
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct   = idle_tab[ph];
      stall_pct  = stall_tab[ph];
      char_count = 0;
      while (char_count < PHASE_CHARS) begin
        if ($urandom_range(0, 3) != 0) queue_expression();
        else queue_noise();
        wait_sent();
      end
    end

    // stack full: overflow is sticky, so this comes last of all
    idle_pct  = 24;
    stall_pct = 24;
    repeat (itp_pkg::STACK_DEPTH + 1) queue_char(itp_pkg::CH_OPEN, 1'b0);
    queue_char("a", 1'b1);
    wait_sent();

    while (postfix_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (postfix_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", postfix_beats.size()));

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/itp_pkg.sv
src/itp_stack.sv
src/infix_to_postfix_converter_core.sv
test/tb.sv
